// File: hdl/u16u8_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and byte-forming function for the utf-16 to utf-8 encoder
package u16u8_pkg;

  // width of the per-string byte counter, fixed to the width of byte_count
  localparam int CountW = 16;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOBUF = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  // one queued job: up to two characters and an optional error word
  typedef struct packed {
    logic [20:0]       cp_a;
    logic [2:0]        len_a;
    logic [15:0]       cp_b;
    logic [1:0]        len_b;
    status_t           err;
    logic [2:0]        total;
    logic [CountW-1:0] base;
  } job_t;

  // byte k of the utf-8 form of cp, whose length is len
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [2:0] k);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      3'd1: begin
        b = {1'b0, cp[6:0]};
      end
      3'd2: begin
        if (k == 3'd0) b = {3'b110, cp[10:6]};
        else           b = {2'b10, cp[5:0]};
      end
      3'd3: begin
        if (k == 3'd0)      b = {4'b1110, cp[15:12]};
        else if (k == 3'd1) b = {2'b10, cp[11:6]};
        else                b = {2'b10, cp[5:0]};
      end
      3'd4: begin
        if (k == 3'd0)      b = {5'b11110, cp[20:18]};
        else if (k == 3'd1) b = {2'b10, cp[17:12]};
        else if (k == 3'd2) b = {2'b10, cp[11:6]};
        else                b = {2'b10, cp[5:0]};
      end
      default: begin
        b = 8'h00;
      end
    endcase
    return b;
  endfunction

endpackage

// File: hdl/u16u8_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for code units and utf-8 bytes
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        first_unit;
  logic        final_unit;

  modport source (output valid, code_unit, first_unit, final_unit, input ready);
  modport sink (input valid, code_unit, first_unit, final_unit, output ready);
endinterface

interface u16u8_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic [1:0]  status;
  logic [15:0] byte_count;

  modport source (output valid, out_byte, last_byte, status, byte_count, input ready);
  modport sink (input valid, out_byte, last_byte, status, byte_count, output ready);
endinterface

// File: hdl/u16u8_front.sv
`timescale 1ns / 1ps
// front end: takes code units, pairs surrogates, checks capacity, issues jobs
module u16u8_front (
  input  logic               clk,
  input  logic               rst_n,
  u16u8_in_if.sink           in_ch,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               q_full,
  output logic               q_push,
  output u16u8_pkg::job_t    q_data
);
  import u16u8_pkg::*;

  logic [15:0]       cap_r;
  logic              pend_r, pend_nxt;
  logic [9:0]        hi_r, hi_nxt;
  logic [CountW-1:0] bw_r, bw_nxt;
  logic              stop_r, stop_nxt;

  logic              accept;
  logic [15:0]       u;
  logic              pend, stop;
  logic [9:0]        hi;
  logic [CountW-1:0] bw;
  logic              is_hi, is_lo;
  logic [2:0]        la_full, la;
  logic [1:0]        lb_full, lb;
  logic [20:0]       cp_a;
  logic [CountW:0]   lim, sum_a, sum_ab;
  logic              fit_a, fit_ab;
  status_t           err;
  logic [2:0]        total;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign u           = in_ch.code_unit;

  // a first unit clears the string state before the unit is handled
  assign pend = in_ch.first_unit ? 1'b0 : pend_r;
  assign hi   = in_ch.first_unit ? 10'd0 : hi_r;
  assign bw   = in_ch.first_unit ? '0 : bw_r;
  assign stop = in_ch.first_unit ? 1'b0 : stop_r;

  assign is_hi = (u[15:10] == 6'b110110);
  assign is_lo = (u[15:10] == 6'b110111);

  assign la_full = !pend ? 3'd0 : (is_lo ? 3'd4 : 3'd3);
  assign lb_full = (u <= 16'h007F) ? 2'd1 : ((u <= 16'h07FF) ? 2'd2 : 2'd3);
  assign cp_a    = is_lo ? (21'h10000 + {1'b0, hi, u[9:0]}) : {5'b0, 6'b110110, hi};

  // capacity limit: the register or the counter maximum, whichever is smaller
  assign lim    = {1'b0, cap_r};
  assign sum_a  = {1'b0, bw} + {{(CountW - 2){1'b0}}, la_full};
  assign sum_ab = {1'b0, bw} + {{(CountW - 2){1'b0}}, la_full + {1'b0, lb_full}};
  assign fit_a  = (sum_a <= lim);
  assign fit_ab = (sum_ab <= lim);

  always_comb begin
    pend_nxt = pend;
    hi_nxt   = hi;
    stop_nxt = stop;
    la       = 3'd0;
    lb       = 2'd0;
    err      = ST_OK;
    if (!stop) begin
      pend_nxt = 1'b0;
      hi_nxt   = 10'd0;
      if (pend && !fit_a) begin
        err      = ST_NOBUF;
        stop_nxt = 1'b1;
      end else begin
        la = la_full;
        if (pend && is_lo) begin
          lb = 2'd0;
        end else if (is_hi) begin
          if (in_ch.final_unit) begin
            err      = ST_TRUNC;
            stop_nxt = 1'b1;
          end else begin
            pend_nxt = 1'b1;
            hi_nxt   = u[9:0];
          end
        end else if (fit_ab) begin
          lb = lb_full;
        end else begin
          err      = ST_NOBUF;
          stop_nxt = 1'b1;
        end
      end
    end
    bw_nxt = bw + {{(CountW - 3){1'b0}}, la + {1'b0, lb}};
    total  = la + {1'b0, lb} + ((err != ST_OK) ? 3'd1 : 3'd0);
  end

  assign q_push       = accept && (total != 3'd0);
  assign q_data.cp_a  = cp_a;
  assign q_data.len_a = la;
  assign q_data.cp_b  = u;
  assign q_data.len_b = lb;
  assign q_data.err   = err;
  assign q_data.total = total;
  assign q_data.base  = bw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= 16'hFFFF;
      pend_r <= 1'b0;
      hi_r   <= 10'd0;
      bw_r   <= '0;
      stop_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (accept) begin
        pend_r <= pend_nxt;
        hi_r   <= hi_nxt;
        bw_r   <= bw_nxt;
        stop_r <= stop_nxt;
      end
    end
  end

endmodule

// File: hdl/u16u8_fifo.sv
`timescale 1ns / 1ps
// short job queue between front and back
module u16u8_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_data,
  output logic            full,
  input  logic            pop,
  output u16u8_pkg::job_t head,
  output logic            empty
);
  import u16u8_pkg::*;

  job_t             mem_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt;
  logic [QPtrW-1:0] rd_r, rd_nxt;
  logic [QPtrW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == QDepth[QPtrW:0]);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/u16u8_back.sv
`timescale 1ns / 1ps
// back end: walks each job one word per cycle into the output register while the output is not stalled
module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  u16u8_pkg::job_t head,
  input  logic            q_empty,
  output logic            q_pop,
  u16u8_out_if.source     out_ch
);
  import u16u8_pkg::*;

  logic [2:0]        idx_r, idx_nxt;
  logic              vld_r, vld_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  status_t           st_r, st_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;

  logic       load, step, in_a, is_err;
  logic [2:0] lab;

  assign load = !vld_r || out_ch.ready;
  assign step = !q_empty && load;
  assign lab  = head.len_a + {1'b0, head.len_b};
  assign in_a = (idx_r < head.len_a);
  assign is_err = !(idx_r < lab);
  assign q_pop = step && (idx_r == head.total - 3'd1);

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r && !out_ch.ready;
    byte_nxt = byte_r;
    last_nxt = last_r;
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    if (step) begin
      vld_nxt  = 1'b1;
      idx_nxt  = q_pop ? 3'd0 : idx_r + 3'd1;
      last_nxt = q_pop;
      st_nxt   = is_err ? head.err : ST_OK;
      // error words carry the count so far, byte words include themselves
      cnt_nxt  = head.base + {{(CountW - 3){1'b0}}, idx_r}
               + (is_err ? {CountW{1'b0}} : {{(CountW - 1){1'b0}}, 1'b1});
      if (is_err)    byte_nxt = 8'h00;
      else if (in_a) byte_nxt = utf8_byte(head.cp_a, head.len_a, idx_r);
      else           byte_nxt = utf8_byte({5'b0, head.cp_b}, {1'b0, head.len_b},
                                          idx_r - head.len_a);
    end
  end

  assign out_ch.valid      = vld_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.last_byte  = last_r;
  assign out_ch.status     = st_r;
  assign out_ch.byte_count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    st_r   <= st_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// File: hdl/utf16_to_utf8_encoder.sv
`timescale 1ns / 1ps
// Top level of the utf-16 to utf-8 encoder. Code units arrive one word at a time on in_ch
// and utf-8 bytes leave one word per cycle on out_ch unless out_ch.ready stalls them. A code
// unit that completes a character produces one to four byte words (up to six when a held
// high surrogate is flushed as three bytes ahead of a new character); a high surrogate that
// is not final is held and produces nothing. The front end takes a new code unit every cycle
// as long as its four-entry job queue has room, so input and output stall independently;
// sustained throughput is set by the output side at one byte per cycle while out_ch is not
// stalled. The first byte of an accepted unit passes through the job queue and then the
// output register before it is presented on out_ch. A character is only emitted if all its
// bytes fit under out_capacity; otherwise a single error word (byte zero, status insufficient
// buffer) is sent and the string is stopped until the next first_unit. A high surrogate on
// the final unit gives a truncated-pair error word. The last word caused by each input
// carries last_byte. cfg_we/cfg_wdata write out_capacity (reset 65535) and should only be
// used while the block is idle.
module utf16_to_utf8_encoder (
  input  logic         clk,
  input  logic         rst_n,
  u16u8_in_if.sink     in_ch,
  u16u8_out_if.source  out_ch,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import u16u8_pkg::*;

  // job queue hookup
  logic q_push, q_pop, q_full, q_empty;
  job_t q_wdata, q_head;

  // front: surrogate pairing, capacity check, string state
  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // decoupling queue, one entry per input that yields words
  u16u8_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // back: byte serializer with registered output
  u16u8_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hdl/u16u8_checker.sv
`timescale 1ns / 1ps
// port-level checks on the encoder output, bound to the top level
module u16u8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        last_byte,
  input logic [1:0]  status,
  input logic [15:0] byte_count
);
  import u16u8_pkg::*;

  // error words end the response of their input
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> last_byte)
    else $error("error word without last_byte");

  // error words carry a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (out_byte == 8'h00))
    else $error("error word with nonzero byte");

  // ok words always count at least one byte
  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_OK) |-> (byte_count != 16'd0))
    else $error("ok word with zero byte count");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_count))
    else $error("stalled output word changed");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .last_byte  (out_ch.last_byte),
  .status     (out_ch.status),
  .byte_count (out_ch.byte_count)
);
